// ----- src/calendar_date_info_core_defines.svh -----
// assertion macros used by the calendar date info core design file
`ifndef CALENDAR_DATE_INFO_CORE_DEFINES_SVH
`define CALENDAR_DATE_INFO_CORE_DEFINES_SVH

// generic clocked check, disabled while reset is asserted
`define CDI_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// same check on the standard clock and reset port names
`define CDI_ASSERT_DEF(label, prop, msg) \
  `CDI_ASSERT(label, clk_i, rst_ni, prop, msg)

`endif

// ----- src/cdi_pkg.sv -----
// types, constants and calendar tables for the calendar date info core
`default_nettype none

package cdi_pkg;

  localparam int DayW  = 5;
  localparam int MonW  = 4;
  localparam int YearW = 14;
  localparam int WdW   = 3;
  localparam int DoyW  = 9;
  localparam int MaskW = 7;

  localparam logic [MaskW-1:0] MaskReset  = 7'd96;
  localparam logic [WdW-1:0]   WdSaturday = 3'd6;
  localparam logic [MonW-1:0]  MonFeb     = 4'd2;
  localparam logic [MonW-1:0]  MonDec     = 4'd12;

  // floor(x / 25) == (x * Recip25) >> RecipShift for x below 16384
  localparam logic [12:0] Recip25    = 13'd5243;
  localparam int          RecipShift = 17;

  typedef struct packed {
    logic            date_valid;
    logic [WdW-1:0]  weekday;
    logic            leap_year;
    logic            weekend_flag;
    logic            business_day;
    logic            end_of_week;
    logic [DoyW-1:0] day_of_year;
    logic [WdW-1:0]  days_to_week_end;
    logic [DayW-1:0] days_to_month_end;
    logic [DoyW-1:0] days_to_year_end;
  } res_t;

  // days in a month of a common year
  function automatic logic [DayW-1:0] month_len(input logic [MonW-1:0] m);
    logic [DayW-1:0] r;
    case (m)
      4'd1:    r = 5'd31;
      4'd2:    r = 5'd28;
      4'd3:    r = 5'd31;
      4'd4:    r = 5'd30;
      4'd5:    r = 5'd31;
      4'd6:    r = 5'd30;
      4'd7:    r = 5'd31;
      4'd8:    r = 5'd31;
      4'd9:    r = 5'd30;
      4'd10:   r = 5'd31;
      4'd11:   r = 5'd30;
      4'd12:   r = 5'd31;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // days before the first of the month in a common year
  function automatic logic [DoyW-1:0] cum_days(input logic [MonW-1:0] m);
    logic [DoyW-1:0] r;
    case (m)
      4'd1:    r = 9'd0;
      4'd2:    r = 9'd31;
      4'd3:    r = 9'd59;
      4'd4:    r = 9'd90;
      4'd5:    r = 9'd120;
      4'd6:    r = 9'd151;
      4'd7:    r = 9'd181;
      4'd8:    r = 9'd212;
      4'd9:    r = 9'd243;
      4'd10:   r = 9'd273;
      4'd11:   r = 9'd304;
      4'd12:   r = 9'd334;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // (31 * mm) / 12 with mm counted from March as one
  function automatic logic [4:0] month_offset(input logic [MonW-1:0] m);
    logic [4:0] r;
    case (m)
      4'd1:    r = 5'd28;
      4'd2:    r = 5'd31;
      4'd3:    r = 5'd2;
      4'd4:    r = 5'd5;
      4'd5:    r = 5'd7;
      4'd6:    r = 5'd10;
      4'd7:    r = 5'd12;
      4'd8:    r = 5'd15;
      4'd9:    r = 5'd18;
      4'd10:   r = 5'd20;
      4'd11:   r = 5'd23;
      4'd12:   r = 5'd25;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // 8 is 1 mod 7, so octal digits fold
  function automatic logic [WdW-1:0] mod7(input logic [14:0] x);
    logic [5:0] s1;
    logic [3:0] s2;
    s1 = 6'(x[2:0]) + 6'(x[5:3]) + 6'(x[8:6]) + 6'(x[11:9]) + 6'(x[14:12]);
    s2 = 4'(s1[2:0]) + 4'(s1[5:3]);
    if (s2 >= 4'd7) begin
      s2 = s2 - 4'd7;
    end
    return s2[2:0];
  endfunction

endpackage

`default_nettype wire

// ----- src/cdi_if.sv -----
// valid/ready channel interfaces for dates, results and the weekend mask
`default_nettype none

interface cdi_in_if import cdi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DayW-1:0]  day;
  logic [MonW-1:0]  month;
  logic [YearW-1:0] year;

  modport source (output valid, output day, output month, output year, input ready);
  modport sink (input valid, input day, input month, input year, output ready);
endinterface

interface cdi_out_if import cdi_pkg::*; ();
  logic            valid;
  logic            ready;
  logic            date_valid;
  logic [WdW-1:0]  weekday;
  logic            leap_year;
  logic            weekend_flag;
  logic            business_day;
  logic            end_of_week;
  logic [DoyW-1:0] day_of_year;
  logic [WdW-1:0]  days_to_week_end;
  logic [DayW-1:0] days_to_month_end;
  logic [DoyW-1:0] days_to_year_end;

  modport source (
    output valid, output date_valid, output weekday, output leap_year,
    output weekend_flag, output business_day, output end_of_week,
    output day_of_year, output days_to_week_end, output days_to_month_end,
    output days_to_year_end, input ready
  );
  modport sink (
    input valid, input date_valid, input weekday, input leap_year,
    input weekend_flag, input business_day, input end_of_week,
    input day_of_year, input days_to_week_end, input days_to_month_end,
    input days_to_year_end, output ready
  );
endinterface

interface cdi_cfg_if import cdi_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [MaskW-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- src/calendar_date_info_core.sv -----
// top level: weekday, leap year and day counts for a Gregorian date
//
//   port    dir  carries
//   in_i    in   day, month, year
//   res_o   out  one result transaction per date
//   cfg_i   in   weekend mask write
//
// a date passes the date input register, then the result register
// one date per cycle sustained while res_o is ready; the calendar logic between the registers is combinational
// stalls on res_o back up through both registers to in_i.ready
// cfg_i is always ready; reset sets the weekend mask to Friday and Saturday
// reset clears both pipeline valid bits
`default_nettype none
`include "calendar_date_info_core_defines.svh"

module calendar_date_info_core import cdi_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  cdi_in_if.sink      in_i,
  cdi_out_if.source   res_o,
  cdi_cfg_if.sink     cfg_i
);

  logic             in_valid_q, in_valid_d;
  logic [DayW-1:0]  day_q;
  logic [MonW-1:0]  month_q;
  logic [YearW-1:0] year_q;
  logic             res_valid_q, res_valid_d;
  res_t             res_q, res_d;
  logic [MaskW-1:0] mask_q, mask_d;

  logic s1_ready, s2_ready;

  assign s2_ready   = !res_valid_q || res_o.ready;
  assign s1_ready   = !in_valid_q || s2_ready;
  assign in_i.ready = s1_ready;
  assign cfg_i.ready = 1'b1;

  assign in_valid_d  = s1_ready ? in_i.valid : in_valid_q;
  assign res_valid_d = s2_ready ? in_valid_q : res_valid_q;
  assign mask_d      = cfg_i.valid ? cfg_i.data : mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
      mask_q      <= MaskReset;
    end else begin
      in_valid_q  <= in_valid_d;
      res_valid_q <= res_valid_d;
      mask_q      <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_ready) begin
      day_q   <= in_i.day;
      month_q <= in_i.month;
      year_q  <= in_i.year;
    end
    if (in_valid_q && s2_ready) begin
      res_q <= res_d;
    end
  end

  // leap year: divisible by 4, and not by 100 unless by 400 (by 16 and 25)
  logic [26:0]      y_prod;
  logic [9:0]       y_div25;
  logic [YearW-1:0] y_mod25;
  logic             leap;

  assign y_prod  = 27'(year_q) * 27'(Recip25);
  assign y_div25 = y_prod[26:RecipShift];
  assign y_mod25 = year_q - (YearW'({y_div25, 4'b0}) + YearW'({y_div25, 3'b0})
                   + YearW'(y_div25));
  assign leap    = (year_q[1:0] == 2'b00) && ((y_mod25 != '0) || (year_q[3:0] == 4'b0));

  // month length and date check
  logic [DayW-1:0] dim;
  logic            valid;

  assign dim   = month_len(month_q) + DayW'(month_q == MonFeb && leap);
  assign valid = (month_q != '0) && (month_q <= MonDec) && (day_q != '0) && (day_q <= dim);

  // weekday congruence with January and February counted in the prior year
  logic [14:0] yy;
  logic [25:0] c_prod;
  logic [8:0]  cent;
  logic [14:0] wsum;
  logic [WdW-1:0] wd;

  assign yy     = 15'(year_q) + 15'd400 - 15'(month_q <= MonFeb);
  assign c_prod = 26'(yy[14:2]) * 26'(Recip25);
  assign cent   = c_prod[25:RecipShift];
  assign wsum   = 15'(day_q) + yy + 15'(yy[14:2]) + 15'(cent[8:2])
                  + 15'(month_offset(month_q)) - 15'(cent);
  assign wd     = mod7(wsum);

  logic [DoyW-1:0] doy;
  logic [DoyW-1:0] ylen;
  logic            wk;

  assign doy  = DoyW'(day_q) + cum_days(month_q) + DoyW'(leap && month_q > MonFeb);
  assign ylen = leap ? 9'd366 : 9'd365;
  assign wk   = mask_q[wd];

  always_comb begin
    res_d = '0;
    if (valid) begin
      res_d.date_valid        = 1'b1;
      res_d.weekday           = wd;
      res_d.leap_year         = leap;
      res_d.weekend_flag      = wk;
      res_d.business_day      = !wk;
      res_d.end_of_week       = (wd == WdSaturday);
      res_d.day_of_year       = doy;
      res_d.days_to_week_end  = WdSaturday - wd;
      res_d.days_to_month_end = dim - day_q + DayW'(1);
      res_d.days_to_year_end  = ylen - doy + DoyW'(1);
    end
  end

  assign res_o.valid             = res_valid_q;
  assign res_o.date_valid        = res_q.date_valid;
  assign res_o.weekday           = res_q.weekday;
  assign res_o.leap_year         = res_q.leap_year;
  assign res_o.weekend_flag      = res_q.weekend_flag;
  assign res_o.business_day      = res_q.business_day;
  assign res_o.end_of_week       = res_q.end_of_week;
  assign res_o.day_of_year       = res_q.day_of_year;
  assign res_o.days_to_week_end  = res_q.days_to_week_end;
  assign res_o.days_to_month_end = res_q.days_to_month_end;
  assign res_o.days_to_year_end  = res_q.days_to_year_end;

  `CDI_ASSERT_DEF(a_invalid_zero,
    res_valid_q && !res_q.date_valid |-> res_q.weekday == '0 && res_q.leap_year == 1'b0
      && res_q.day_of_year == '0 && res_q.days_to_year_end == '0,
    "invalid date result carries nonzero fields")
  `CDI_ASSERT_DEF(a_business_day,
    res_valid_q && res_q.date_valid |-> res_q.business_day != res_q.weekend_flag,
    "business day flag does not mirror weekend flag")
  `CDI_ASSERT_DEF(a_week_end,
    res_valid_q && res_q.date_valid |-> (4'(res_q.weekday) + 4'(res_q.days_to_week_end))
      == 4'd6 && res_q.end_of_week == (res_q.weekday == WdSaturday),
    "weekday and days to week end disagree")
  `CDI_ASSERT_DEF(a_year_len,
    res_valid_q && res_q.date_valid |-> (10'(res_q.day_of_year)
      + 10'(res_q.days_to_year_end)) == (10'd366 + 10'(res_q.leap_year)),
    "day of year and days to year end disagree")

endmodule

`default_nettype wire

// ----- tb/calendar_date_info_core_tb.sv -----
// testbench for the calendar date info core: directed dates, random dates, result checks
`timescale 1ns / 1ps

module calendar_date_info_core_tb import cdi_pkg::*; ();

  localparam int HoldCycles = 80;
  localparam int StallLimit = 2000;
  localparam int NumRows    = 22;

  typedef struct {
    logic [DayW-1:0]  day;
    logic [MonW-1:0]  month;
    logic [YearW-1:0] year;
    bit               typed;
    res_t             res;
  } date_row_t;

  localparam res_t NoDate = '0;
  localparam res_t FirstDate = '{date_valid: 1'b1, weekday: 3'd1, leap_year: 1'b0,
                                 weekend_flag: 1'b0, business_day: 1'b1, end_of_week: 1'b0,
                                 day_of_year: 9'd1, days_to_week_end: 3'd5,
                                 days_to_month_end: 5'd31, days_to_year_end: 9'd365};
  localparam res_t LastDate = '{date_valid: 1'b1, weekday: 3'd5, leap_year: 1'b0,
                                weekend_flag: 1'b1, business_day: 1'b0, end_of_week: 1'b0,
                                day_of_year: 9'd365, days_to_week_end: 3'd1,
                                days_to_month_end: 5'd1, days_to_year_end: 9'd1};

  logic clk_i;
  logic rst_ni;

  cdi_in_if  in_if ();
  cdi_out_if res_if ();
  cdi_cfg_if cfg_if ();

  calendar_date_info_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  res_t             expected_q[$];
  logic [MaskW-1:0] wk_mask;
  int               err_cnt;
  int               snd_idle;
  int               rcv_stall;
  bit               hold_req;
  bit               hold_done;
  int               hold_left;
  int               quiet_cycles;
  date_row_t        dir_rows [NumRows];

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic bit is_leap_year(input int y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int month_days(input int y, input int m);
    case (m)
      1, 3, 5, 7, 8, 10, 12: return 31;
      4, 6, 9, 11:           return 30;
      2:                     return is_leap_year(y) ? 29 : 28;
      default:               return 0;
    endcase
  endfunction

  function automatic res_t predict_date(input logic [DayW-1:0] d, input logic [MonW-1:0] m,
                                        input logic [YearW-1:0] y,
                                        input logic [MaskW-1:0] mask);
    res_t r;
    int   dd, mo, yr, len, a, ys, ms, wd, doy;
    bit   leap;
    r  = '0;
    dd = int'(d);
    mo = int'(m);
    yr = int'(y);
    len = month_days(yr, mo);
    // a bad month has length zero, so this also covers it
    if (dd < 1 || dd > len) begin
      return r;
    end
    leap = is_leap_year(yr);
    // year counted from march; the extra 400 years keep the sum positive
    a  = (mo < 3) ? 1 : 0;
    ys = yr + 400 - a;
    ms = mo + 12 * a - 2;
    wd = (dd + ys + ys / 4 + ys / 400 + (31 * ms) / 12 - ys / 100) % 7;
    doy = dd;
    for (int k = 1; k < mo; k++) begin
      doy += month_days(yr, k);
    end
    r.date_valid        = 1'b1;
    r.weekday           = WdW'(wd);
    r.leap_year         = leap;
    r.weekend_flag      = mask[wd];
    r.business_day      = ~mask[wd];
    r.end_of_week       = (WdW'(wd) == WdSaturday);
    r.day_of_year       = DoyW'(doy);
    r.days_to_week_end  = WdW'(6 - wd);
    r.days_to_month_end = DayW'(len - dd + 1);
    r.days_to_year_end  = DoyW'((leap ? 366 : 365) - doy + 1);
    return r;
  endfunction

  // mostly real dates, the rest any bit pattern
  task automatic gen_date(output logic [DayW-1:0] d, output logic [MonW-1:0] m,
                          output logic [YearW-1:0] y);
    int yr, mo;
    if ($urandom_range(99) < 85) begin
      yr = ($urandom_range(9) == 0) ? $urandom_range(16383) : $urandom_range(9999, 1);
      mo = $urandom_range(12, 1);
      y  = YearW'(yr);
      m  = MonW'(mo);
      case ($urandom_range(5))
        0:       d = 5'd1;
        1:       d = DayW'(month_days(yr, mo));
        default: d = DayW'($urandom_range(month_days(yr, mo), 1));
      endcase
    end else begin
      d = DayW'($urandom_range(31));
      m = MonW'($urandom_range(15));
      y = YearW'($urandom_range(16383));
    end
  endtask

  task automatic send_date(input logic [DayW-1:0] d, input logic [MonW-1:0] m,
                           input logic [YearW-1:0] y, input bit typed, input res_t typed_res);
    res_t want;
    while ($urandom_range(99) < snd_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    want = typed ? typed_res : predict_date(d, m, y, wk_mask);
    in_if.valid = 1'b1;
    in_if.day   = d;
    in_if.month = m;
    in_if.year  = y;
    do @(posedge clk_i); while (!in_if.ready);
    expected_q.push_back(want);
    @(negedge clk_i);
  endtask

  task automatic run_random(input int n);
    logic [DayW-1:0]  d;
    logic [MonW-1:0]  m;
    logic [YearW-1:0] y;
    repeat (n) begin
      gen_date(d, m, y);
      send_date(d, m, y, 1'b0, NoDate);
    end
  endtask

  task automatic drain_results();
    in_if.valid = 1'b0;
    while (expected_q.size() != 0) begin
      @(negedge clk_i);
    end
    // two pipeline stages, plus margin
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_mask(input logic [MaskW-1:0] mask);
    drain_results();
    cfg_if.valid = 1'b1;
    cfg_if.data  = mask;
    do @(posedge clk_i); while (!cfg_if.ready);
    wk_mask = mask;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endtask

  // receiver: random stalls, or a long hold-off when asked
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_left = HoldCycles;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else begin
      res_if.ready = ($urandom_range(99) >= rcv_stall);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_if.valid && res_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("result transaction with no date pending");
        err_cnt++;
      end else begin
        want = expected_q.pop_front();
        check_field("date_valid", int'(want.date_valid), int'(res_if.date_valid));
        check_field("weekday", int'(want.weekday), int'(res_if.weekday));
        check_field("leap_year", int'(want.leap_year), int'(res_if.leap_year));
        check_field("weekend_flag", int'(want.weekend_flag), int'(res_if.weekend_flag));
        check_field("business_day", int'(want.business_day), int'(res_if.business_day));
        check_field("end_of_week", int'(want.end_of_week), int'(res_if.end_of_week));
        check_field("day_of_year", int'(want.day_of_year), int'(res_if.day_of_year));
        check_field("days_to_week_end", int'(want.days_to_week_end),
                    int'(res_if.days_to_week_end));
        check_field("days_to_month_end", int'(want.days_to_month_end),
                    int'(res_if.days_to_month_end));
        check_field("days_to_year_end", int'(want.days_to_year_end),
                    int'(res_if.days_to_year_end));
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    rst_ni       = 1'b0;
    in_if.valid  = 1'b0;
    in_if.day    = '0;
    in_if.month  = '0;
    in_if.year   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    wk_mask      = MaskReset;
    snd_idle     = 0;
    rcv_stall    = 0;
    hold_req     = 1'b0;

    dir_rows = '{
      '{5'd1,  4'd1,  14'd1,     1'b1, FirstDate},
      '{5'd31, 4'd12, 14'd9999,  1'b1, LastDate},
      '{5'd1,  4'd0,  14'd2000,  1'b1, NoDate},
      '{5'd1,  4'd13, 14'd2000,  1'b1, NoDate},
      '{5'd31, 4'd15, 14'd16383, 1'b1, NoDate},
      '{5'd0,  4'd6,  14'd2023,  1'b1, NoDate},
      '{5'd0,  4'd0,  14'd0,     1'b1, NoDate},
      '{5'd29, 4'd2,  14'd2001,  1'b1, NoDate},
      '{5'd29, 4'd2,  14'd1900,  1'b1, NoDate},
      '{5'd31, 4'd4,  14'd2023,  1'b1, NoDate},
      '{5'd29, 4'd2,  14'd2000,  1'b0, NoDate},
      '{5'd29, 4'd2,  14'd2024,  1'b0, NoDate},
      '{5'd30, 4'd4,  14'd2023,  1'b0, NoDate},
      '{5'd29, 4'd2,  14'd0,     1'b0, NoDate},
      '{5'd1,  4'd3,  14'd0,     1'b0, NoDate},
      '{5'd31, 4'd12, 14'd16383, 1'b0, NoDate},
      '{5'd1,  4'd1,  14'd10000, 1'b0, NoDate},
      '{5'd28, 4'd2,  14'd2100,  1'b0, NoDate},
      '{5'd31, 4'd12, 14'd2000,  1'b0, NoDate},
      '{5'd1,  4'd1,  14'd2000,  1'b0, NoDate},
      '{5'd4,  4'd7,  14'd1776,  1'b0, NoDate},
      '{5'd15, 4'd10, 14'd1582,  1'b0, NoDate}
    };

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed dates under the reset weekend mask
    foreach (dir_rows[i]) begin
      send_date(dir_rows[i].day, dir_rows[i].month, dir_rows[i].year,
                dir_rows[i].typed, dir_rows[i].res);
    end

    write_mask('0);
    run_random(300);

    write_mask('1);
    snd_idle = 88;
    run_random(300);

    write_mask(MaskW'($urandom_range(127)));
    snd_idle  = 0;
    rcv_stall = 88;
    run_random(300);

    write_mask(MaskW'($urandom_range(127)));
    snd_idle  = 15;
    rcv_stall = 15;
    run_random(300);

    // long receiver hold-off while dates keep coming, so the input backs up
    write_mask(MaskReset);
    snd_idle  = 0;
    rcv_stall = 0;
    hold_req  = 1'b1;
    run_random(200);

    // sender waits for every pending result before going on
    drain_results();
    write_mask(MaskW'($urandom_range(127)));
    snd_idle  = 40;
    rcv_stall = 40;
    run_random(200);

    drain_results();
    repeat (10) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- calendar_date_info_core.f -----
+incdir+src
src/cdi_pkg.sv
src/cdi_if.sv
src/calendar_date_info_core.sv
tb/calendar_date_info_core_tb.sv
